// ===== design/tpf_pkg.sv =====
// tpf_pkg: shared types, field widths, command codes and microcode rom
// for the text to page framebuffer block; no dependencies
package tpf_pkg;

  // default geometry and font store size
  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int FONT_BYTES_DEF = 1280;

  // payload field widths
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 8;
  localparam int FADDR_W = 11;
  localparam int BYTE_W  = 8;
  localparam int PADDR_W = 10;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 12;

  // configuration register widths
  localparam int CFG_IDX_W = 2;
  localparam int SW_W      = 8;
  localparam int SH_W      = 7;
  localparam int SCALE_W   = 4;

  localparam logic [SW_W-1:0]    RST_SCREEN_WIDTH  = 8'd128;
  localparam logic [SH_W-1:0]    RST_SCREEN_HEIGHT = 7'd64;
  localparam logic [SCALE_W-1:0] RST_SCALE         = 4'd1;

  localparam logic [CMD_W-1:0] CMD_PUT_CHAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_FONT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_BYTE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y       = 2'd3;

  localparam logic [CODE_W-1:0] CHAR_LF        = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_CR        = 8'h0D;
  localparam logic [CODE_W-1:0] CODE_HIGH_SKIP = 8'd176;

  localparam int GLYPH_COLS = 5;
  localparam int COL_IDX_W  = 3;
  localparam int CELL_PITCH = 6;
  localparam int PAGE_ROWS  = 8;
  localparam int GIDX_W     = 12;

  localparam logic [ROW_W-1:0] ROW_MAX = 12'hFFF;

  // microcode step addresses, in program order
  typedef enum logic [4:0] {
    ST_BOOT_INIT   = 5'd0,
    ST_BOOT_CLR    = 5'd1,
    ST_IDLE        = 5'd2,
    ST_LOAD        = 5'd3,
    ST_READ        = 5'd4,
    ST_READ_WAIT   = 5'd5,
    ST_CLR_INIT    = 5'd6,
    ST_CLR_LOOP    = 5'd7,
    ST_PUT_NL_CHK  = 5'd8,
    ST_PUT_CR_CHK  = 5'd9,
    ST_WRAP        = 5'd10,
    ST_SETUP       = 5'd11,
    ST_COL_RD      = 5'd12,
    ST_COL_WR0     = 5'd13,
    ST_COL_WR1     = 5'd14,
    ST_ADVANCE     = 5'd15,
    ST_NEWLINE     = 5'd16,
    ST_EMIT        = 5'd17
  } step_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_BOOT_INIT,
    A_CLR_INIT,
    A_CLR_WR,
    A_ACCEPT,
    A_FONT_WR,
    A_FRAME_RD,
    A_CAPTURE_BYTE,
    A_WRAP,
    A_SETUP,
    A_COL_RD,
    A_COL_WR0,
    A_COL_WR1,
    A_ADVANCE,
    A_LINE_ADV,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_NEWLINE,
    C_CR,
    C_CLIPPED,
    C_COL_MORE,
    C_CNT_DONE,
    C_OUT_FREE
  } cond_t;

  // one control word per step
  typedef struct packed {
    act_t  act;
    cond_t cond;
    logic  disp;    // on taken jump, go through the command dispatch table
    logic  hold;    // on failed condition, stay instead of falling through
    logic  rdy;     // input channel ready
    step_t target;
  } ctl_word_t;

  function automatic ctl_word_t cw(act_t a, cond_t c, logic d, logic h, logic r,
                                   step_t t);
    ctl_word_t w;
    w.act    = a;
    w.cond   = c;
    w.disp   = d;
    w.hold   = h;
    w.rdy    = r;
    w.target = t;
    return w;
  endfunction

  function automatic ctl_word_t ucode(step_t pc);
    ctl_word_t w;
    case (pc)
      ST_BOOT_INIT:  w = cw(A_BOOT_INIT,    C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_BOOT_CLR);
      ST_BOOT_CLR:   w = cw(A_CLR_WR,       C_CNT_DONE, 1'b0, 1'b1, 1'b0, ST_IDLE);
      ST_IDLE:       w = cw(A_ACCEPT,       C_ACCEPT,   1'b1, 1'b1, 1'b1, ST_IDLE);
      ST_LOAD:       w = cw(A_FONT_WR,      C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_EMIT);
      ST_READ:       w = cw(A_FRAME_RD,     C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_READ_WAIT);
      ST_READ_WAIT:  w = cw(A_CAPTURE_BYTE, C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_EMIT);
      ST_CLR_INIT:   w = cw(A_CLR_INIT,     C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_CLR_LOOP);
      ST_CLR_LOOP:   w = cw(A_CLR_WR,       C_CNT_DONE, 1'b0, 1'b1, 1'b0, ST_EMIT);
      ST_PUT_NL_CHK: w = cw(A_NONE,         C_NEWLINE,  1'b0, 1'b0, 1'b0, ST_NEWLINE);
      ST_PUT_CR_CHK: w = cw(A_NONE,         C_CR,       1'b0, 1'b0, 1'b0, ST_EMIT);
      ST_WRAP:       w = cw(A_WRAP,         C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_SETUP);
      ST_SETUP:      w = cw(A_SETUP,        C_CLIPPED,  1'b0, 1'b0, 1'b0, ST_ADVANCE);
      ST_COL_RD:     w = cw(A_COL_RD,       C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_COL_WR0);
      ST_COL_WR0:    w = cw(A_COL_WR0,      C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_COL_WR1);
      ST_COL_WR1:    w = cw(A_COL_WR1,      C_COL_MORE, 1'b0, 1'b0, 1'b0, ST_COL_RD);
      ST_ADVANCE:    w = cw(A_ADVANCE,      C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_EMIT);
      ST_NEWLINE:    w = cw(A_LINE_ADV,     C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_EMIT);
      ST_EMIT:       w = cw(A_EMIT,         C_OUT_FREE, 1'b0, 1'b1, 1'b0, ST_IDLE);
      default:       w = cw(A_NONE,         C_ALWAYS,   1'b0, 1'b0, 1'b0, ST_IDLE);
    endcase
    return w;
  endfunction

  // first step of each command
  function automatic step_t dispatch(logic [CMD_W-1:0] cmd);
    step_t s;
    case (cmd)
      CMD_PUT_CHAR:  s = ST_PUT_NL_CHK;
      CMD_CLEAR:     s = ST_CLR_INIT;
      CMD_LOAD_FONT: s = ST_LOAD;
      CMD_READ_BYTE: s = ST_READ;
      default:       s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ===== design/tpf_stream_if.sv =====
// tpf_in_if and tpf_out_if: valid/ready channels for command beats and
// result beats; depends on tpf_pkg for field widths
interface tpf_in_if import tpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [CODE_W-1:0]  char_code;
  logic [FADDR_W-1:0] font_addr;
  logic [BYTE_W-1:0]  font_data;
  logic [PADDR_W-1:0] frame_addr;

  modport source (output valid, cmd, char_code, font_addr, font_data, frame_addr,
                  input ready);
  modport sink   (input valid, cmd, char_code, font_addr, font_data, frame_addr,
                  output ready);
endinterface

interface tpf_out_if import tpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  modport source (output valid, frame_byte, cursor_col, cursor_row, input ready);
  modport sink   (input valid, frame_byte, cursor_col, cursor_row, output ready);
endinterface

// ===== design/text_to_page_framebuffer_core.sv =====
// text_to_page_framebuffer_core: microcoded text renderer into a page organized
// monochrome framebuffer; depends on tpf_pkg and tpf_stream_if
//
// Each command beat on in_ch gives one result beat on out_ch carrying the
// byte read (zero unless the command was a framebuffer read) and the cursor
// after the command. A step counter walks a microcode rom in tpf_pkg, from the
// idle step that takes the beat to the step that loads the result register.
// Put char renders five glyph columns of three steps each (glyph and page
// read, write of the upper page byte, write of the lower page byte) and skips
// them when the cell is wholly off the panel; newline and carriage return
// render nothing. Clear writes width * ceil(height / 8) framebuffer bytes, one
// framebuffer byte a cycle through the single write port. After reset a
// clearing pass zeroes all MAX_WIDTH * ceil(MAX_HEIGHT / 8) framebuffer bytes
// with in_ch.ready low; configuration writes are taken at any time. A new beat
// is taken while the previous result still waits on out_ch; the final step of
// that new beat waits for the result register.
module text_to_page_framebuffer_core import tpf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FONT_BYTES = FONT_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tpf_in_if.sink               in_ch,
  tpf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SW_W-1:0]      cfg_wdata
);

  // geometry of the stores
  localparam int PAGES       = (MAX_HEIGHT + 7) / 8;
  localparam int FRAME_BYTES = MAX_WIDTH * PAGES;
  localparam int FA_W        = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int GA_W        = $clog2(FONT_BYTES);
  localparam int W_W         = $clog2(MAX_WIDTH + 1);
  localparam int H_W         = $clog2(MAX_HEIGHT + 1);

  // sequencer
  step_t     pc_r, pc_nxt;
  ctl_word_t ctl;
  logic      cond_ok;

  // configuration
  logic [SW_W-1:0]    scr_w_r;
  logic [SH_W-1:0]    scr_h_r;
  logic [SCALE_W-1:0] scale_x_r;
  logic [SCALE_W-1:0] scale_y_r;
  logic [W_W-1:0]     eff_w;
  logic [H_W-1:0]     eff_h;

  // cursor
  logic [COL_W-1:0]   cursor_x_r;
  logic [ROW_W-1:0]   cursor_y_r;
  logic [6:0]         adv;
  logic [COL_W-1:0]   adv_sum;
  logic               wrap_need;
  logic [ROW_W:0]     y_sum;
  logic [ROW_W-1:0]   y_line;

  // captured command fields
  logic [CODE_W-1:0]  code_r;
  logic [FADDR_W-1:0] faddr_r;
  logic [BYTE_W-1:0]  fdata_r;
  logic [PADDR_W-1:0] paddr_r;
  logic               paddr_ok;
  logic               faddr_ok;
  logic [BYTE_W-1:0]  byte_r;

  // clear sweep
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_end_r;
  logic [CNT_W-1:0]   clr_n;
  logic [4:0]         clr_pages;
  logic               cnt_done;

  // glyph render
  logic [COL_IDX_W-1:0] col_r;
  logic [FA_W-1:0]      base0_r, base1_r;
  logic [FA_W-1:0]      base0_s, base1_s;
  logic [GIDX_W-1:0]    gbase_r, gbase_s;
  logic [PAGE_ROWS-1:0] mask0_r, mask1_r;
  logic [PAGE_ROWS-1:0] mask0_s, mask1_s;
  logic [2:0]           shift_r;
  logic [3:0]           page_s;
  logic [CODE_W:0]      code_adj;
  logic                 clipped;
  logic                 col_ok;
  logic [BYTE_W-1:0]    gbits;
  logic [2*BYTE_W-1:0]  spread;
  logic [GIDX_W-1:0]    gidx;
  logic                 goor;

  // memories
  logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] glyph_mem [FONT_BYTES];
  logic [BYTE_W-1:0] frame_rd_r;
  logic [BYTE_W-1:0] glyph_rd_r;
  logic              glyph_oor_r;
  logic              fwe, fre;
  logic [FA_W-1:0]   fwaddr, fraddr;
  logic [BYTE_W-1:0] fwdata;
  logic              gwe, gre;
  logic [GA_W-1:0]   graddr;

  // handshakes
  logic              accept;
  logic              out_free;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;

  assign ctl          = ucode(pc_r);
  assign in_ch.ready  = ctl.rdy;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;

  // oversized geometry acts as the store limit
  assign eff_w = (32'(scr_w_r) > 32'(MAX_WIDTH))  ? W_W'(MAX_WIDTH)  : W_W'(scr_w_r);
  assign eff_h = (32'(scr_h_r) > 32'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : H_W'(scr_h_r);

  // cursor arithmetic
  assign adv       = 7'(32'(scale_x_r) * CELL_PITCH);
  assign adv_sum   = COL_W'(32'(cursor_x_r) + 32'(adv));
  assign wrap_need = (32'(cursor_x_r) + 32'(adv)) > 32'(eff_w);
  assign y_sum     = {1'b0, cursor_y_r} + (ROW_W+1)'({scale_y_r, 3'b000});
  assign y_line    = y_sum[ROW_W] ? ROW_MAX : y_sum[ROW_W-1:0];

  assign paddr_ok = 32'(paddr_r) < 32'(FRAME_BYTES);
  assign faddr_ok = 32'(faddr_r) < 32'(FONT_BYTES);

  // clear length: width times pages covering the height
  assign clr_pages = 5'((32'(eff_h) + 7) >> 3);
  assign clr_n     = CNT_W'(32'(eff_w) * 32'(clr_pages));
  assign cnt_done  = (32'(cnt_r) + 1) >= 32'(cnt_end_r);

  // render setup: page bases, row masks, glyph base index
  assign clipped  = (32'(cursor_x_r) >= 32'(eff_w)) || (32'(cursor_y_r) >= 32'(eff_h));
  assign page_s   = cursor_y_r[6:3];
  assign code_adj = {1'b0, code_r} + (CODE_W+1)'(code_r >= CODE_HIGH_SKIP);
  assign gbase_s  = GIDX_W'(32'(code_adj) * GLYPH_COLS);
  assign base0_s  = FA_W'(32'(cursor_x_r) + 32'(page_s) * 32'(eff_w));
  assign base1_s  = FA_W'(32'(base0_s) + 32'(eff_w));

  always_comb begin
    for (int k = 0; k < PAGE_ROWS; k++) begin
      mask0_s[k] = (32'(page_s) * PAGE_ROWS + k) < 32'(eff_h);
      mask1_s[k] = (32'(page_s) * PAGE_ROWS + PAGE_ROWS + k) < 32'(eff_h);
    end
  end

  // per column datapath
  assign col_ok = (32'(cursor_x_r) + 32'(col_r)) < 32'(eff_w);
  assign gbits  = glyph_oor_r ? '0 : glyph_rd_r;
  assign spread = (2*BYTE_W)'({{BYTE_W{1'b0}}, gbits} << shift_r);
  assign gidx   = gbase_r + GIDX_W'(col_r);
  assign goor   = 32'(gidx) >= 32'(FONT_BYTES);
  assign graddr = GA_W'(gidx);
  assign gre    = (ctl.act == A_COL_RD);
  assign gwe    = (ctl.act == A_FONT_WR) && faddr_ok;

  // framebuffer port control
  always_comb begin
    fwe    = 1'b0;
    fwaddr = cnt_r[FA_W-1:0];
    fwdata = '0;
    fre    = 1'b0;
    fraddr = FA_W'(paddr_r);
    case (ctl.act)
      A_CLR_WR: begin
        fwe = 32'(cnt_r) < 32'(cnt_end_r);
      end
      A_FRAME_RD: begin
        fre = 1'b1;
      end
      A_COL_RD: begin
        fre    = 1'b1;
        fraddr = base0_r + FA_W'(col_r);
      end
      A_COL_WR0: begin
        // upper page: or in the shifted glyph, read the lower page
        fwe    = col_ok;
        fwaddr = base0_r + FA_W'(col_r);
        fwdata = frame_rd_r | (spread[BYTE_W-1:0] & mask0_r);
        fre    = 1'b1;
        fraddr = base1_r + FA_W'(col_r);
      end
      A_COL_WR1: begin
        // lower page only when some of its rows are on the panel
        fwe    = col_ok && (mask1_r != '0);
        fwaddr = base1_r + FA_W'(col_r);
        fwdata = frame_rd_r | (spread[2*BYTE_W-1:BYTE_W] & mask1_r);
      end
      default: ;
    endcase
  end

  // sequencer: condition, jump or fall through
  always_comb begin
    case (ctl.cond)
      C_ALWAYS:   cond_ok = 1'b1;
      C_ACCEPT:   cond_ok = accept;
      C_NEWLINE:  cond_ok = (code_r == CHAR_LF);
      C_CR:       cond_ok = (code_r == CHAR_CR);
      C_CLIPPED:  cond_ok = clipped;
      C_COL_MORE: cond_ok = (col_r != COL_IDX_W'(GLYPH_COLS - 1));
      C_CNT_DONE: cond_ok = cnt_done;
      C_OUT_FREE: cond_ok = out_free;
      default:    cond_ok = 1'b0;
    endcase
    if (cond_ok) begin
      pc_nxt = ctl.disp ? dispatch(in_ch.cmd) : ctl.target;
    end else if (ctl.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = step_t'(pc_r + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_BOOT_INIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // control state: configuration, cursor, sweep counter, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r     <= RST_SCREEN_WIDTH;
      scr_h_r     <= RST_SCREEN_HEIGHT;
      scale_x_r   <= RST_SCALE;
      scale_y_r   <= RST_SCALE;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      cnt_r       <= '0;
      cnt_end_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:  scr_w_r   <= cfg_wdata;
          CFG_SCREEN_HEIGHT: scr_h_r   <= cfg_wdata[SH_W-1:0];
          CFG_SCALE_X:       scale_x_r <= cfg_wdata[SCALE_W-1:0];
          CFG_SCALE_Y:       scale_y_r <= cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      case (ctl.act)
        A_BOOT_INIT: begin
          cnt_r     <= '0;
          cnt_end_r <= CNT_W'(FRAME_BYTES);
        end
        A_CLR_INIT: begin
          cnt_r     <= '0;
          cnt_end_r <= clr_n;
        end
        A_CLR_WR: begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        A_WRAP: begin
          if (wrap_need) begin
            cursor_x_r <= '0;
            cursor_y_r <= y_line;
          end
        end
        A_LINE_ADV: begin
          cursor_x_r <= '0;
          cursor_y_r <= y_line;
        end
        A_ADVANCE: begin
          cursor_x_r <= adv_sum;
        end
        default: ;
      endcase
      if (ctl.act == A_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r  <= in_ch.char_code;
      faddr_r <= in_ch.font_addr;
      fdata_r <= in_ch.font_data;
      paddr_r <= in_ch.frame_addr;
      byte_r  <= '0;
    end
    case (ctl.act)
      A_CAPTURE_BYTE: begin
        byte_r <= paddr_ok ? frame_rd_r : '0;
      end
      A_SETUP: begin
        col_r   <= '0;
        base0_r <= base0_s;
        base1_r <= base1_s;
        gbase_r <= gbase_s;
        mask0_r <= mask0_s;
        mask1_r <= mask1_s;
        shift_r <= cursor_y_r[2:0];
      end
      A_COL_WR1: begin
        col_r <= col_r + COL_IDX_W'(1);
      end
      A_EMIT: begin
        if (out_free) begin
          out_byte_r <= byte_r;
          out_col_r  <= cursor_x_r;
          out_row_r  <= cursor_y_r;
        end
      end
      default: ;
    endcase
  end

  // framebuffer memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (fwe) begin
      frame_mem[fwaddr] <= fwdata;
    end
    if (fre) begin
      frame_rd_r <= frame_mem[fraddr];
    end
  end

  // font memory, with the out of range flag kept next to its read data
  always_ff @(posedge clk) begin
    if (gwe) begin
      glyph_mem[GA_W'(faddr_r)] <= fdata_r;
    end
    if (gre) begin
      glyph_rd_r  <= glyph_mem[graddr];
      glyph_oor_r <= goor;
    end
  end

`ifndef SYNTH
  // beats are taken only by the idle step
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (pc_r == ST_IDLE))
    else $error("command beat taken outside idle step");

  // framebuffer writes only come from the clear sweeps and the column steps
  a_frame_wr_step: assert property (@(posedge clk) disable iff (!rst_n)
    fwe |-> (pc_r == ST_BOOT_CLR || pc_r == ST_CLR_LOOP ||
             pc_r == ST_COL_WR0 || pc_r == ST_COL_WR1))
    else $error("framebuffer write from unexpected step");

  // a result loaded into a free register is offered next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.act == A_EMIT && out_free) |=> out_ch.valid)
    else $error("result not offered after emit");

  // the power-on clear runs before the first beat
  a_boot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ch.ready)
    else $error("ready right after reset");
`endif

endmodule
